@@ rtl/dmx_pkg.sv @@
// Shared types and constants of the mono downmix block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package dmx_pkg;

	// APB register port geometry
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register indexes (taken from paddr[2])
	localparam logic REG_NUM_CHANNELS = 1'b0;
	localparam logic REG_WIDTH_MODE   = 1'b1;

	// sample width modes; the unused code behaves as 32-bit signed
	localparam logic [1:0] WMODE_U8  = 2'd0;
	localparam logic [1:0] WMODE_S16 = 2'd1;
	localparam logic [1:0] WMODE_S32 = 2'd2;

	// register reset values
	localparam logic [3:0] NUM_CHANNELS_RST = 4'd2;
	localparam logic [1:0] WIDTH_MODE_RST   = WMODE_S16;

	// sample and result widths
	localparam int SAMPLE_W = 32;

	// sequencer states
	typedef enum logic [2:0] {
		DMX_IDLE,
		DMX_LOAD,
		DMX_DIV,
		DMX_FIX,
		DMX_OUT
	} dmx_state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} dmx_div_stat_t;

endpackage

@@ rtl/dmx_if.sv @@
// Valid/ready channel interfaces for the sample input and the mono output.
// Depends on dmx_pkg for the sample width.
`timescale 1ns / 1ps

interface dmx_in_if import dmx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_word;

	modport source (output valid, output sample_word, input ready);
	modport sink   (input valid, input sample_word, output ready);
endinterface

interface dmx_out_if import dmx_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] mono_sample;

	modport source (output valid, output mono_sample, input ready);
	modport sink   (input valid, input mono_sample, output ready);
endinterface

@@ rtl/dmx_cfg_regs.sv @@
// APB configuration registers: channel count and sample width mode.
// Depends on dmx_pkg for addresses, codes and reset values.
`timescale 1ns / 1ps

module dmx_cfg_regs import dmx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [3:0]            num_channels,
	output logic [1:0]            sample_width_mode
);

	logic [3:0] num_channels_q;
	logic [1:0] width_mode_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_channels_q <= NUM_CHANNELS_RST;
			width_mode_q   <= WIDTH_MODE_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_NUM_CHANNELS: num_channels_q <= pwdata[3:0];
				REG_WIDTH_MODE:   width_mode_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[2])
			REG_NUM_CHANNELS: prdata = {{(APB_DATA_W-4){1'b0}}, num_channels_q};
			REG_WIDTH_MODE:   prdata = {{(APB_DATA_W-2){1'b0}}, width_mode_q};
			default:          prdata = '0;
		endcase
	end

	assign num_channels      = num_channels_q;
	assign sample_width_mode = width_mode_q;

endmodule

@@ rtl/dmx_divider.sv @@
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on dmx_pkg for the status struct.
`timescale 1ns / 1ps

module dmx_divider import dmx_pkg::*; #(
	parameter int DIVIDEND_W = 35,
	parameter int DIVISOR_W  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output dmx_div_stat_t         stat
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/multichannel_to_mono_downmix.sv @@
// Multichannel to mono downmix: accumulate one frame, average, clamp.
// Usage:
//   sample_ch (valid/ready) takes interleaved channel samples, one per beat,
//   as raw little-endian words; mono_ch (valid/ready) gives one mono sample
//   per frame. The APB port holds num_channels (0x0) and sample_width_mode
//   (0x4); 0 channels acts as 1, more than MAX_CHANNELS acts as MAX_CHANNELS.
// Timing:
//   A sample that does not end a frame is added to the sum and the block
//   stays ready. The last sample of a frame sends the sequencer through
//   LOAD (divider start), DIV, FIX (sign restore) and OUT (output load);
//   the serial divider gives one quotient bit per cycle over the
//   33 + clog2(MAX_CHANNELS) bit sum magnitude, and sample_ch is not ready
//   until the sequencer is back in IDLE.
// Reset:
//   arst_n clears the partial frame, the output valid flag and the sequencer;
//   registers return to 2 channels, 16-bit signed.
// Stall:
//   A result waits in the output register while mono_ch is not ready; the
//   next frame may be accumulated meanwhile, and its result holds in the
//   sequencer until the register frees.
// Depends on dmx_pkg, dmx_if, dmx_cfg_regs and dmx_divider.
`timescale 1ns / 1ps

module multichannel_to_mono_downmix import dmx_pkg::*; #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dmx_in_if.sink                sample_ch,
	dmx_out_if.source             mono_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int SUM_W = SAMPLE_W + 1 + $clog2(MAX_CHANNELS);

	logic [3:0]          num_channels;
	logic [1:0]          width_mode;
	logic [CNT_W-1:0]    eff_n;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    cnt_inc;
	logic                frame_end;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    dec;
	logic [SUM_W-1:0]    mag;
	logic                neg_q;
	logic [SUM_W-1:0]    avg_q;
	logic [SUM_W-1:0]    quotient;
	logic [SAMPLE_W-1:0] clamped;
	logic [SAMPLE_W-1:0] mono_q;
	logic                out_valid_q;
	logic                accept;
	logic                div_start;
	logic                out_load;
	logic                in_ready;
	dmx_div_stat_t       div_stat;
	dmx_state_t          state_q;
	dmx_state_t          state_d;

	dmx_cfg_regs u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.num_channels      (num_channels),
		.sample_width_mode (width_mode)
	);

	dmx_divider #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  (eff_n),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// effective channel count: zero acts as one, saturate at the maximum
	always_comb begin
		if (num_channels == 4'd0) begin
			eff_n = CNT_W'(1);
		end else if (32'(num_channels) > 32'(MAX_CHANNELS)) begin
			eff_n = CNT_W'(MAX_CHANNELS);
		end else begin
			eff_n = CNT_W'(num_channels);
		end
	end

	// decode the raw word to a sign- or zero-extended sample
	always_comb begin
		case (width_mode)
			WMODE_U8:  dec = {{(SUM_W-8){1'b0}}, sample_ch.sample_word[7:0]};
			WMODE_S16: dec = {{(SUM_W-16){sample_ch.sample_word[15]}},
				sample_ch.sample_word[15:0]};
			default:   dec = {{(SUM_W-SAMPLE_W){sample_ch.sample_word[SAMPLE_W-1]}},
				sample_ch.sample_word};
		endcase
	end

	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign frame_end = cnt_inc >= eff_n;
	assign accept    = sample_ch.valid & in_ready;
	assign mag       = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

	// clamp the average to the configured width
	always_comb begin
		case (width_mode)
			WMODE_U8: clamped = {{(SAMPLE_W-8){1'b0}}, avg_q[7:0]};
			WMODE_S16: begin
				if ((&avg_q[SUM_W-1:15]) | ~(|avg_q[SUM_W-1:15])) begin
					clamped = {{(SAMPLE_W-16){1'b0}}, avg_q[15:0]};
				end else if (avg_q[SUM_W-1]) begin
					clamped = 32'h0000_8000;
				end else begin
					clamped = 32'h0000_7FFF;
				end
			end
			default: begin
				if ((&avg_q[SUM_W-1:SAMPLE_W-1]) | ~(|avg_q[SUM_W-1:SAMPLE_W-1])) begin
					clamped = avg_q[SAMPLE_W-1:0];
				end else if (avg_q[SUM_W-1]) begin
					clamped = 32'h8000_0000;
				end else begin
					clamped = 32'h7FFF_FFFF;
				end
			end
		endcase
	end

	// sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			DMX_IDLE: begin
				in_ready = 1'b1;
				if (sample_ch.valid && frame_end) begin
					state_d = DMX_LOAD;
				end
			end
			DMX_LOAD: begin
				div_start = 1'b1;
				state_d   = DMX_DIV;
			end
			DMX_DIV: begin
				if (div_stat.done) begin
					state_d = DMX_FIX;
				end
			end
			DMX_FIX: state_d = DMX_OUT;
			DMX_OUT: begin
				if (!out_valid_q || mono_ch.ready) begin
					out_load = 1'b1;
					state_d  = DMX_IDLE;
				end
			end
			default: state_d = DMX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DMX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// accumulate the frame; clear it once the divider has its operand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else if (accept) begin
			sum_q <= sum_q + dec;
			cnt_q <= frame_end ? '0 : cnt_inc;
		end else if (div_start) begin
			neg_q <= sum_q[SUM_W-1];
			sum_q <= '0;
		end
	end

	// restore the sign of the quotient
	always_ff @(posedge clk) begin
		if (state_q == DMX_FIX) begin
			avg_q <= neg_q ? (~quotient + SUM_W'(1)) : quotient;
		end
	end

	// output register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (mono_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mono_q <= clamped;
		end
	end

	assign sample_ch.ready     = in_ready;
	assign mono_ch.valid       = out_valid_q;
	assign mono_ch.mono_sample = mono_q;

endmodule
